// ===== hdl/ptca_pkg.sv =====
// Shared types and constants for the per-task cycle accounting block.
// Used by ptca_ctrl, ptca_dp and per_task_cycle_accounting; no dependencies.
package ptca_pkg;

  localparam int NumCores  = 4;
  localparam int NumPrios  = 64;
  localparam int TaskDepth = NumCores * NumPrios;
  localparam int TaskAw    = $clog2(TaskDepth);

  localparam logic [31:0] WordMax = 32'hFFFF_FFFF;
  localparam logic [15:0] PendMax = 16'hFFFF;

  // Configuration register byte addresses
  localparam int          PaddrW        = 3;
  localparam logic [PaddrW-1:0] CfgEnableAddr = 3'h0;

  typedef enum logic [1:0] {
    OP_WRAP  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_END   = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request fields and read the task table
    logic execute;  // update state and load the result register
  } cmd_t;

endpackage

// ===== hdl/ptca_ctrl.sv =====
// Controller for the per-task cycle accounting block: two-state sequencer
// and result-valid flag. Depends on ptca_pkg.
module ptca_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ptca_pkg::cmd_t  cmd_o
);

  ptca_pkg::state_e state_q, state_d;
  logic             out_vld_q, out_vld_d;
  logic             slot_free;

  assign slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_vld_d   = out_vld_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ptca_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ptca_pkg::ST_EXEC;
        end
      end
      ptca_pkg::ST_EXEC: begin
        // hold until the result register can take the new result
        if (slot_free) begin
          cmd_o.execute = 1'b1;
          out_vld_d     = 1'b1;
          state_d       = ptca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptca_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== hdl/ptca_dp.sv =====
// Datapath for the per-task cycle accounting block: per-core registers,
// the task accumulator table with valid bits, and the result register.
// Depends on ptca_pkg.
module ptca_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptca_pkg::cmd_t  cmd_i,
  input  logic            enable_i,
  input  logic [1:0]      op_i,
  input  logic [1:0]      core_i,
  input  logic [5:0]      prio_i,
  input  logic [31:0]     counter_value_i,
  output logic [31:0]     entry_count_o,
  output logic [31:0]     entry_wraps_o,
  output logic [31:0]     core_wraps_o,
  output logic            clock_error_o
);

  // Request latch
  logic [1:0]  op_q;
  logic [1:0]  core_q;
  logic [5:0]  prio_q;
  logic [31:0] cnt_q;

  // Per-core state
  logic [31:0] start_q [ptca_pkg::NumCores];
  logic [15:0] pend_q  [ptca_pkg::NumCores];
  logic [31:0] total_q [ptca_pkg::NumCores];

  // Task table: {high, low}
  logic [63:0]                    task_mem [ptca_pkg::TaskDepth];
  logic [ptca_pkg::TaskDepth-1:0] task_vld_q;
  logic [63:0]                    rd_q;
  logic                           rd_vld_q;
  logic [ptca_pkg::TaskAw-1:0]    rd_addr, wr_addr_q;

  // Result register
  logic [31:0] res_low_q, res_high_q, res_core_q;
  logic        res_err_q;

  // Execute-phase logic
  logic        core_ok, prio_ok, is_wrap, is_begin, is_end;
  logic [31:0] prev, total, low_old, high_old, delta, total_new;
  logic [15:0] pend, pend_used;
  logic        fwd, err;
  logic [32:0] sum;
  logic [31:0] high_new;

  assign rd_addr = ptca_pkg::TaskAw'(32'(core_i) * ptca_pkg::NumPrios + 32'(prio_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      core_q    <= core_i;
      prio_q    <= prio_i;
      cnt_q     <= counter_value_i;
      rd_q      <= task_mem[rd_addr];
      wr_addr_q <= rd_addr;
    end
    if (cmd_i.execute && is_end) begin
      task_mem[wr_addr_q] <= {high_new, sum[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.capture) begin
      rd_vld_q <= task_vld_q[rd_addr];
    end
  end

  assign core_ok  = 32'(core_q) < ptca_pkg::NumCores;
  assign prio_ok  = 32'(prio_q) < ptca_pkg::NumPrios;
  assign is_wrap  = core_ok && (op_q == ptca_pkg::OP_WRAP);
  assign is_begin = core_ok && (op_q == ptca_pkg::OP_BEGIN) && enable_i;
  assign is_end   = core_ok && (op_q == ptca_pkg::OP_END) && enable_i && prio_ok;

  always_comb begin
    prev      = start_q[core_q];
    pend      = pend_q[core_q];
    total     = total_q[core_q];
    // an entry never written since reset reads as zero
    low_old   = rd_vld_q ? rd_q[31:0]  : '0;
    high_old  = rd_vld_q ? rd_q[63:32] : '0;
    fwd       = cnt_q >= prev;
    err       = !fwd && (pend == '0);
    // modular difference covers both the forward and the wrapped case
    delta     = err ? '0 : (cnt_q - prev);
    pend_used = (!fwd && !err) ? (pend - 16'd1) : pend;
    sum       = {1'b0, low_old} + {1'b0, delta};
    high_new  = high_old + 32'(sum[32]) + 32'(pend_used);
    total_new = total + 32'(pend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_vld_q <= '0;
      for (int i = 0; i < ptca_pkg::NumCores; i++) begin
        start_q[i] <= '0;
        pend_q[i]  <= '0;
        total_q[i] <= '0;
      end
    end else if (cmd_i.execute) begin
      if (is_wrap && (pend != ptca_pkg::PendMax)) begin
        pend_q[core_q] <= pend + 16'd1;
      end
      if (is_begin) begin
        start_q[core_q] <= cnt_q;
      end
      if (is_begin || is_end) begin
        total_q[core_q] <= total_new;
        pend_q[core_q]  <= '0;
      end
      if (is_end) begin
        task_vld_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_low_q  <= is_end ? sum[31:0] : '0;
      res_high_q <= is_end ? high_new  : '0;
      res_err_q  <= is_end && err;
      if (!core_ok) begin
        res_core_q <= '0;
      end else if (is_begin || is_end) begin
        res_core_q <= total_new;
      end else begin
        res_core_q <= total;
      end
    end
  end

  assign entry_count_o = res_low_q;
  assign entry_wraps_o = res_high_q;
  assign core_wraps_o  = res_core_q;
  assign clock_error_o = res_err_q;

endmodule

// ===== hdl/per_task_cycle_accounting.sv =====
// Top level of the per-task cycle accounting block: stream ports, APB register
// and assertions. Depends on ptca_pkg, ptca_ctrl and ptca_dp.
//
// Each event runs as a capture step, in which the accepted event reads the task
// table entry, and an execute step, which updates the per-core registers and
// writes the entry back, loading the result register; one event is in work at a
// time, and a new one is accepted while the previous result still waits on the
// output. A result that is not taken holds the execute step of the following
// event. The task table is 256 entries of 64 bits with one valid bit per entry,
// cleared at reset at once, so no clearing pass is needed.
module per_task_cycle_accounting (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // core[1:0], prio[7:2], counter_value[39:8]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // entry_count[31:0], entry_wraps[63:32],
                                      // core_wraps[95:64]
  output logic        m_axis_tuser,   // clock_error[0]
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptca_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ptca_pkg::cmd_t cmd;
  logic           enable_q;
  logic [31:0]    entry_count, entry_wraps, core_wraps;
  logic           clock_error;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr == ptca_pkg::CfgEnableAddr)) begin
      enable_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == ptca_pkg::CfgEnableAddr) ? {31'd0, enable_q} : '0;

  ptca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ptca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .enable_i        (enable_q),
    .op_i            (s_axis_tuser),
    .core_i          (s_axis_tdata[1:0]),
    .prio_i          (s_axis_tdata[7:2]),
    .counter_value_i (s_axis_tdata[39:8]),
    .entry_count_o   (entry_count),
    .entry_wraps_o   (entry_wraps),
    .core_wraps_o    (core_wraps),
    .clock_error_o   (clock_error)
  );

  assign m_axis_tdata = {core_wraps, entry_wraps, entry_count};
  assign m_axis_tuser = clock_error;

  // An accepted event blocks the input for its execute cycle
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted during execute");

  // Every execute leaves a valid result
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.execute |=> m_axis_tvalid)
    else $error("execute without result");

  // Execute only follows a captured event
  a_exec_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.execute |-> !s_axis_tready && !cmd.capture)
    else $error("execute without pending event");

endmodule

// ===== test/ptca_checker.sv =====
// Checker for the per-task cycle accounting block: follows the enable register,
// predicts each result from the accepted requests and compares it field by field.
// Depends on ptca_pkg.
module ptca_checker
  import ptca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // core[1:0], prio[7:2], counter_value[39:8]
  input  logic [1:0]        s_axis_tuser,  // op[1:0]
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [95:0]       m_axis_tdata,  // entry_count, entry_wraps, core_wraps
  input  logic              m_axis_tuser,  // clock_error[0]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] entry_count;
    logic [31:0] entry_wraps;
    logic [31:0] core_wraps;
    logic        clock_error;
  } tally_t;

  logic        enable_q;
  logic [31:0] start_mark [NumCores];
  logic [15:0] pend_wraps [NumCores];
  logic [31:0] core_total [NumCores];
  logic [31:0] acc_low    [TaskDepth];
  logic [31:0] acc_high   [TaskDepth];

  tally_t tally_q [$];
  int     mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic tally_t account_event(logic [1:0] op, logic [1:0] core,
                                           logic [5:0] prio, logic [31:0] cnt);
    tally_t      r;
    int          idx;
    logic [15:0] pend;
    logic [31:0] span;
    logic [32:0] sum;
    r = '0;
    if (int'(core) >= NumCores) return r;
    case (op)
      OP_WRAP: begin
        if (pend_wraps[core] != PendMax) pend_wraps[core] = pend_wraps[core] + 16'd1;
      end
      OP_BEGIN: begin
        if (enable_q) begin
          start_mark[core] = cnt;
          core_total[core] = core_total[core] + 32'(pend_wraps[core]);
          pend_wraps[core] = '0;
        end
      end
      OP_END: begin
        if (enable_q && int'(prio) < NumPrios) begin
          idx  = int'(core) * NumPrios + int'(prio);
          pend = pend_wraps[core];
          span = '0;
          core_total[core] = core_total[core] + 32'(pend);
          if (cnt >= start_mark[core]) begin
            span = cnt - start_mark[core];
          end else if (pend != 0) begin
            // spend one wrap; the modular difference is the elapsed count
            pend = pend - 16'd1;
            span = cnt - start_mark[core];
          end else begin
            r.clock_error = 1'b1;
          end
          sum           = {1'b0, acc_low[idx]} + {1'b0, span};
          acc_low[idx]  = sum[31:0];
          acc_high[idx] = acc_high[idx] + 32'(sum[32]) + 32'(pend);
          pend_wraps[core] = '0;
          r.entry_count = acc_low[idx];
          r.entry_wraps = acc_high[idx];
        end
      end
      default: ;
    endcase
    r.core_wraps = core_total[core];
    return r;
  endfunction

  task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("%0t ptca_checker: %s expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    tally_t got;
    if (!rst_ni) begin
      enable_q = 1'b0;
      for (int i = 0; i < NumCores; i++) begin
        start_mark[i] = '0;
        pend_wraps[i] = '0;
        core_total[i] = '0;
      end
      for (int i = 0; i < TaskDepth; i++) begin
        acc_low[i]  = '0;
        acc_high[i] = '0;
      end
      tally_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CfgEnableAddr)
        enable_q = pwdata[0];
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
        if (tally_q.size() == 0) begin
          note_failure("result with no request pending, core_wraps", '0, got.core_wraps);
        end else begin
          want = tally_q.pop_front();
          if (got.entry_count !== want.entry_count)
            note_failure("entry_count", want.entry_count, got.entry_count);
          if (got.entry_wraps !== want.entry_wraps)
            note_failure("entry_wraps", want.entry_wraps, got.entry_wraps);
          if (got.core_wraps !== want.core_wraps)
            note_failure("core_wraps", want.core_wraps, got.core_wraps);
          if (got.clock_error !== want.clock_error)
            note_failure("clock_error", 32'(want.clock_error), 32'(got.clock_error));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        tally_q.push_back(account_event(s_axis_tuser, s_axis_tdata[1:0],
                                        s_axis_tdata[7:2], s_axis_tdata[39:8]));
    end
    outstanding_o <= tally_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the per-task cycle accounting testbench: clock, reset, event stimulus,
// register writes and the verdict. Depends on ptca_pkg, ptca_checker and the block.
module tb_top;
  import ptca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata = '0;   // core[1:0], prio[7:2], counter_value[39:8]
  logic [1:0]         s_axis_tuser = '0;   // op[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [95:0]        m_axis_tdata;        // entry_count, entry_wraps, core_wraps
  logic               m_axis_tuser;        // clock_error[0]
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  per_task_cycle_accounting dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ptca_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_event(logic [1:0] op, logic [1:0] core, logic [5:0] prio,
                            logic [31:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {cnt, prio, core};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every request has its result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enable(logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgEnableAddr;
    pwdata  <= {31'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly complete begin/end pairs with random spans, the rest noise
  task automatic run_tasks(int n_items);
    int          sent;
    int          n_wraps;
    logic [1:0]  core;
    logic [5:0]  prio;
    logic [31:0] start;
    logic [31:0] span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        core  = 2'($urandom_range(3));
        prio  = 6'($urandom_range(63));
        start = $urandom;
        case ($urandom_range(5))
          0, 1, 2: span = $urandom_range(4095);
          3:       span = $urandom;
          4:       span = '0;
          default: span = 32'hFFFF_FFFF - $urandom_range(255);
        endcase
        send_event(OP_BEGIN, core, 6'($urandom), start);
        n_wraps = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n_wraps) send_event(OP_WRAP, core, 6'($urandom), $urandom);
        if ($urandom_range(3) == 0) begin
          send_event(2'($urandom), 2'($urandom), 6'($urandom), $urandom);
          sent++;
        end
        send_event(OP_END, core, prio, start + span);
        sent += 2 + n_wraps;
      end else begin
        send_event(2'($urandom), 2'($urandom), 6'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // enable is low out of reset: wraps still count, begin and end do nothing
    send_event(OP_WRAP,  2'd0, 6'd0,  32'd0);
    send_event(OP_BEGIN, 2'd0, 6'd0,  32'd100);
    send_event(OP_END,   2'd0, 6'd5,  32'd200);
    settle();
    write_enable(1'b1);

    send_event(OP_BEGIN, 2'd0, 6'd0,  32'd0);
    send_event(OP_END,   2'd0, 6'd0,  32'hFFFF_FFFF);
    send_event(OP_BEGIN, 2'd1, 6'd0,  32'd1000);
    send_event(OP_END,   2'd1, 6'd63, 32'd1000);       // equal count
    send_event(OP_BEGIN, 2'd2, 6'd0,  32'd500);
    send_event(OP_END,   2'd2, 6'd7,  32'd10);         // backwards, no wrap
    send_event(OP_BEGIN, 2'd3, 6'd0,  32'hFFFF_FF00);
    send_event(OP_WRAP,  2'd3, 6'd0,  32'd0);
    send_event(OP_WRAP,  2'd3, 6'd0,  32'd0);
    send_event(OP_END,   2'd3, 6'd1,  32'h0000_0100);  // backwards, wrap spent
    send_event(OP_BEGIN, 2'd0, 6'd0,  32'd0);
    send_event(OP_END,   2'd0, 6'd0,  32'hFFFF_FFFF);  // low word carries
    send_event(2'd3,     2'd1, 6'd63, 32'hFFFF_FFFF);  // unused op
    send_event(OP_BEGIN, 2'd2, 6'd0,  32'd5);
    send_event(OP_END,   2'd2, 6'd7,  32'd5);          // zero span on a live entry
    send_event(OP_END,   2'd3, 6'd63, 32'hAAAA_5555);

    // pile up pending wraps on one core, then move them into the entry
    repeat (8) send_event(OP_WRAP, 2'd3, 6'd0, 32'd0);
    send_event(OP_END,   2'd3, 6'd2,  32'd0);
    send_event(OP_BEGIN, 2'd3, 6'd0,  32'h8000_0000);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      write_enable(1'b1);
      run_tasks(360);
      settle();
      write_enable(1'b0);
      run_tasks(30);
      settle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
